### rtl/nrwi_pkg.sv
// Shared constants and controller/datapath interface types for the
// nondecreasing-run block. No dependencies.
package nrwi_pkg;

  localparam int MAX_VALUE   = 4064;
  localparam int MAX_OPS     = 31;
  localparam int ROW_COUNT   = 4095;
  localparam int COL_COUNT   = MAX_OPS + 1;
  localparam int LEN_BITS    = 16;

  localparam int VAL_W       = 12;
  localparam int OPS_W       = 5;
  localparam int ROW_IDX_W   = 12;                // row index, 0 .. ROW_COUNT-1
  localparam int COL_IDX_W   = 5;                 // column index, 0 .. COL_COUNT-1
  localparam int ROW_W       = ROW_IDX_W + 1;     // walker row, may step past ROW_COUNT
  localparam int COL_W       = COL_IDX_W + 2;     // walker column, may step past COL_COUNT
  localparam int MEM_AW      = ROW_IDX_W + COL_IDX_W;
  localparam int MEM_DEPTH   = ROW_COUNT * COL_COUNT;

  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [ROW_W-1:0]    row_t;
  typedef logic [COL_W-1:0]    col_t;
  typedef logic [MEM_AW-1:0]   maddr_t;

  localparam len_t LEN_MAX = {LEN_BITS{1'b1}};

  // Register addresses (word index)
  localparam logic REG_MAX_OPS = 1'b0;

  typedef struct packed {
    logic load_item;  // latch value and increment limit
    logic clr_init;   // restart clearing pass, zero best length
    logic clr_step;   // zero one store entry
    logic q_init;     // start prefix-max walk for current j
    logic q_step;     // issue one query read
    logic u_init;     // form new length, start raise walk
    logic u_step;     // issue one raise read
    logic j_dec;      // move to next lower increment count
    logic out_load;   // capture best length into output register
  } nrwi_cmd_t;

  typedef struct packed {
    logic q_last;     // current query read is the final one
    logic u_last;     // current raise read is the final one
    logic j_zero;     // increment count is zero
    logic clr_last;   // clearing the final store entry
  } nrwi_stat_t;

endpackage

### rtl/nrwi_datapath.sv
// Datapath: Fenwick walkers, 2D prefix-max store, running best length.
// Depends on nrwi_pkg; sequenced by nrwi_ctrl.
module nrwi_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nrwi_pkg::nrwi_cmd_t          cmd,
  input  logic [nrwi_pkg::VAL_W-1:0]   value_in,
  input  logic [nrwi_pkg::OPS_W-1:0]   max_ops,
  output nrwi_pkg::nrwi_stat_t         stat,
  output logic [nrwi_pkg::LEN_BITS-1:0] best_out
);
  import nrwi_pkg::*;

  len_t mem [0:MEM_DEPTH-1];

  logic [VAL_W-1:0] v_r;
  logic [OPS_W-1:0] j_r;
  row_t             r_r;
  col_t             c_r;
  len_t             acc_r;
  len_t             len_r;
  len_t             best_r;
  len_t             out_r;
  len_t             rdata_r;
  logic             qv_r;
  logic             uv_r;
  maddr_t           uaddr_r;
  maddr_t           clr_cnt_r;

  logic [VAL_W-1:0] v_clamp;
  row_t             h_sum;
  row_t             h_row;
  col_t             col;
  row_t             low_r;
  col_t             low_c;
  row_t             r_dn;
  row_t             r_up;
  col_t             c_dn;
  col_t             c_up;
  row_t             r_m1;
  col_t             c_m1;
  maddr_t           rd_addr;
  logic             re;
  logic             we;
  maddr_t           waddr;
  len_t             wdata;
  len_t             len_nxt;

  always_comb begin
    if (value_in == '0) v_clamp = VAL_W'(1);
    else if (value_in > VAL_W'(MAX_VALUE)) v_clamp = VAL_W'(MAX_VALUE);
    else v_clamp = value_in;
  end

  // height value+j, clamped to the store
  assign h_sum = row_t'(v_r) + row_t'(j_r);
  assign h_row = (h_sum > row_t'(ROW_COUNT)) ? row_t'(ROW_COUNT) : h_sum;
  assign col   = col_t'(j_r) + col_t'(1);

  assign low_r = r_r & (~r_r + row_t'(1));
  assign low_c = c_r & (~c_r + col_t'(1));
  assign r_dn  = r_r - low_r;
  assign r_up  = r_r + low_r;
  assign c_dn  = c_r - low_c;
  assign c_up  = c_r + low_c;

  assign stat.q_last   = (c_dn == '0) && (r_dn == '0);
  assign stat.u_last   = (c_up > col_t'(COL_COUNT)) && (r_up > row_t'(ROW_COUNT));
  assign stat.j_zero   = (j_r == '0);
  assign stat.clr_last = (clr_cnt_r == maddr_t'(MEM_DEPTH - 1));

  assign r_m1    = r_r - row_t'(1);
  assign c_m1    = c_r - col_t'(1);
  assign rd_addr = {r_m1[ROW_IDX_W-1:0], c_m1[COL_IDX_W-1:0]};
  assign re      = cmd.q_step | cmd.u_step;

  assign len_nxt = (acc_r == LEN_MAX) ? acc_r : acc_r + len_t'(1);

  always_comb begin
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = '0;
    end else begin
      we    = uv_r && (len_r > rdata_r);
      waddr = uaddr_r;
      wdata = len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r      <= 1'b0;
      uv_r      <= 1'b0;
      clr_cnt_r <= '0;
      best_r    <= '0;
    end else begin
      qv_r <= cmd.q_step;
      uv_r <= cmd.u_step;
      if (cmd.clr_init) begin
        clr_cnt_r <= '0;
        best_r    <= '0;
      end else begin
        if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + maddr_t'(1);
        if (cmd.u_init && (len_nxt > best_r)) best_r <= len_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    uaddr_r <= rd_addr;
    if (cmd.load_item) begin
      v_r <= v_clamp;
      j_r <= max_ops;
    end else if (cmd.j_dec) begin
      j_r <= j_r - OPS_W'(1);
    end

    if (cmd.q_init || cmd.u_init) begin
      r_r <= h_row;
      c_r <= col;
    end else if (cmd.q_step) begin
      if (c_dn == '0) begin
        r_r <= r_dn;
        c_r <= col;
      end else begin
        c_r <= c_dn;
      end
    end else if (cmd.u_step) begin
      if (c_up > col_t'(COL_COUNT)) begin
        r_r <= r_up;
        c_r <= col;
      end else begin
        c_r <= c_up;
      end
    end

    if (cmd.q_init) acc_r <= '0;
    else if (qv_r && (rdata_r > acc_r)) acc_r <= rdata_r;

    if (cmd.u_init) len_r <= len_nxt;
    if (cmd.out_load) out_r <= best_r;
  end

  assign best_out = out_r;

endmodule

### rtl/nrwi_ctrl.sv
// Controller: sequences clearing pass, per-j query and raise walks, and
// the stream handshakes. Depends on nrwi_pkg.
module nrwi_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_start,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  nrwi_pkg::nrwi_stat_t stat,
  output nrwi_pkg::nrwi_cmd_t  cmd
);
  import nrwi_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_QINIT, S_QRY, S_QDRAIN, S_LEN, S_UPD, S_UDRAIN, S_OUT
  } state_t;

  state_t state_r;
  logic   pend_r;
  logic   out_tvalid_r;
  logic   in_acc;
  logic   out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd           = '0;
    cmd.load_item = in_acc;
    cmd.clr_init  = in_acc && in_start;
    case (state_r)
      S_CLEAR:  cmd.clr_step = 1'b1;
      S_QINIT:  cmd.q_init   = 1'b1;
      S_QRY:    cmd.q_step   = 1'b1;
      S_LEN:    cmd.u_init   = 1'b1;
      S_UPD:    cmd.u_step   = 1'b1;
      S_UDRAIN: cmd.j_dec    = !stat.j_zero;
      S_OUT:    cmd.out_load = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if ((state_r == S_OUT) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (stat.clr_last) state_r <= pend_r ? S_QINIT : S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            pend_r  <= 1'b1;
            state_r <= in_start ? S_CLEAR : S_QINIT;
          end
        end
        S_QINIT:  state_r <= S_QRY;
        S_QRY:    if (stat.q_last) state_r <= S_QDRAIN;
        S_QDRAIN: state_r <= S_LEN;
        S_LEN:    state_r <= S_UPD;
        S_UPD:    if (stat.u_last) state_r <= S_UDRAIN;
        S_UDRAIN: state_r <= stat.j_zero ? S_OUT : S_QINIT;
        S_OUT: begin
          if (out_free) begin
            pend_r  <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default:  state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/nondecreasing_run_with_increments.sv
// Longest non-decreasing run with up to max_ops prefix increments, top level.
// Depends on nrwi_pkg, nrwi_ctrl, nrwi_datapath.
//
// Each value returns the best length since the last start. An item runs
// max_ops+1 passes (j from max_ops down to 0); each pass is one read per
// Fenwick cell on the query walk plus one per cell on the raise walk, over
// a single store of 4095 x 32 lengths with one read and one write port, plus
// states S_QINIT, S_QDRAIN, S_LEN and S_UDRAIN per pass and S_IDLE and S_OUT
// per item: at most 12 x 5 query reads and 12 x 6 raise reads per pass, paced
// by that store's one read per cycle. After reset, and on any item with
// start_req set, the store is cleared one entry per cycle (131040 entries)
// before values are handled; no item is accepted during that pass.
// The next item is accepted while the previous result waits in the output
// register.
module nondecreasing_run_with_increments (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // [11:0] value, [15:12] zero
  input  logic                        in_tuser,   // [0] start_req
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [15:0] best_length
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [nrwi_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [nrwi_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [nrwi_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import nrwi_pkg::*;

  logic [OPS_W-1:0] max_ops_r;
  logic             cfg_wr;
  logic             reg_sel;
  nrwi_cmd_t        cmd;
  nrwi_stat_t       stat;
  len_t             best;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[CFG_AW-1] == REG_MAX_OPS);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = reg_sel ? CFG_DW'(max_ops_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ops_r <= '0;
    end else if (cfg_wr && reg_sel) begin
      max_ops_r <= cfg_pwdata[OPS_W-1:0];
    end
  end

  nrwi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_start   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  nrwi_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .value_in (in_tdata[VAL_W-1:0]),
    .max_ops  (max_ops_r),
    .stat     (stat),
    .best_out (best)
  );

  assign out_tdata = best;

endmodule

### rtl/nrwi_checker.sv
// Port-level checks for the top level, attached by bind.
// Depends on nondecreasing_run_with_increments.
module nrwi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [2:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every result counts at least the value just taken
  a_out_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != 16'd0)
    else $error("zero best length reported");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transaction");

  // register read-back
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2])
      ##1 !cfg_paddr[2] |-> cfg_prdata == {27'd0, $past(cfg_pwdata[4:0])})
    else $error("max_ops read-back mismatch");

endmodule

bind nondecreasing_run_with_increments nrwi_checker u_nrwi_checker (.*);
